// ----- rtl/core/apip_pkg.sv -----
// Package for the interleaved ASCON permutation core.
// Holds the state type, round count and interleaved round constants.
// No dependencies.
`default_nettype none

package apip_pkg;

  localparam int unsigned NumLanes   = 5;
  localparam int unsigned LaneWidth  = 64;
  localparam int unsigned HalfWidth  = 32;
  localparam int unsigned RoundCount = 12;

  typedef logic [3:0] round_t;
  typedef logic [HalfWidth-1:0] half_t;
  typedef logic [NumLanes-1:0][LaneWidth-1:0] state_t;
  typedef logic [NumLanes-1:0][HalfWidth-1:0] halves_t;

  localparam round_t LastRound = round_t'(RoundCount - 1);

  localparam logic [3:0] RcEven [RoundCount] = '{
    4'd12, 4'd9, 4'd12, 4'd9, 4'd6, 4'd3, 4'd6, 4'd3, 4'd12, 4'd9, 4'd12, 4'd9
  };
  localparam logic [3:0] RcOdd [RoundCount] = '{
    4'd12, 4'd12, 4'd9, 4'd9, 4'd12, 4'd12, 4'd9, 4'd9, 4'd6, 4'd6, 4'd3, 4'd3
  };

endpackage

`default_nettype wire

// ----- rtl/core/apip_if.sv -----
// Valid/ready channel interfaces for the interleaved ASCON permutation core.
// One interface for the input state, one for the permuted state.
// No dependencies.
`default_nettype none

interface apip_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane0_in;
  logic [63:0] lane1_in;
  logic [63:0] lane2_in;
  logic [63:0] lane3_in;
  logic [63:0] lane4_in;
  logic [3:0]  start_round;

  modport source (
    output valid, lane0_in, lane1_in, lane2_in, lane3_in, lane4_in, start_round,
    input  ready
  );
  modport sink (
    input  valid, lane0_in, lane1_in, lane2_in, lane3_in, lane4_in, start_round,
    output ready
  );
endinterface

interface apip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane0_out;
  logic [63:0] lane1_out;
  logic [63:0] lane2_out;
  logic [63:0] lane3_out;
  logic [63:0] lane4_out;

  modport source (
    output valid, lane0_out, lane1_out, lane2_out, lane3_out, lane4_out,
    input  ready
  );
  modport sink (
    input  valid, lane0_out, lane1_out, lane2_out, lane3_out, lane4_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/apip_round.sv -----
// One ASCON round on a bit-interleaved state: constant add, S-box, diffusion.
// Combinational; depends on apip_pkg.
`default_nettype none

module apip_round (
  input  wire apip_pkg::state_t state_i,
  input  wire apip_pkg::round_t round_i,
  output apip_pkg::state_t      state_o
);
  import apip_pkg::*;

  function automatic half_t ror32(input half_t x, input logic [4:0] k);
    logic [2*HalfWidth-1:0] tmp;
    tmp = {x, x} >> k;
    return tmp[HalfWidth-1:0];
  endfunction

  function automatic halves_t sbox(input halves_t a);
    half_t x0, x1, x2, x3, x4;
    half_t n0, n1, n2, n3, n4;
    halves_t r;
    x0 = a[0] ^ a[4];
    x4 = a[4] ^ a[3];
    x2 = a[2] ^ a[1];
    x1 = a[1];
    x3 = a[3];
    n0 = ~x0 & x1;
    n1 = ~x1 & x2;
    n2 = ~x2 & x3;
    n3 = ~x3 & x4;
    n4 = ~x4 & x0;
    x0 = x0 ^ n1;
    x1 = x1 ^ n2;
    x2 = x2 ^ n3;
    x3 = x3 ^ n4;
    x4 = x4 ^ n0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    r[0] = x0;
    r[1] = x1;
    r[2] = x2;
    r[3] = x3;
    r[4] = x4;
    return r;
  endfunction

  halves_t ev_in, od_in, ev_s, od_s, p, q, ev_o, od_o;
  logic [3:0] rc_ev, rc_od;

  assign rc_ev = (round_i < round_t'(RoundCount)) ? RcEven[round_i] : 4'd0;
  assign rc_od = (round_i < round_t'(RoundCount)) ? RcOdd[round_i]  : 4'd0;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      ev_in[i] = state_i[i][HalfWidth-1:0];
      od_in[i] = state_i[i][LaneWidth-1:HalfWidth];
    end
    ev_in[2] = ev_in[2] ^ {28'd0, rc_ev};
    od_in[2] = od_in[2] ^ {28'd0, rc_od};
  end

  assign ev_s = sbox(ev_in);
  assign od_s = sbox(od_in);

  always_comb begin
    p[0] = ev_s[0] ^ ror32(od_s[0], 5'd4);
    q[0] = od_s[0] ^ ror32(ev_s[0], 5'd5);
    ev_o[0] = ev_s[0] ^ ror32(q[0], 5'd9);
    od_o[0] = od_s[0] ^ ror32(p[0], 5'd10);

    p[1] = ev_s[1] ^ ror32(ev_s[1], 5'd11);
    q[1] = od_s[1] ^ ror32(od_s[1], 5'd11);
    ev_o[1] = ev_s[1] ^ ror32(q[1], 5'd19);
    od_o[1] = od_s[1] ^ ror32(p[1], 5'd20);

    p[2] = ev_s[2] ^ ror32(od_s[2], 5'd2);
    q[2] = od_s[2] ^ ror32(ev_s[2], 5'd3);
    ev_o[2] = ev_s[2] ^ q[2];
    od_o[2] = od_s[2] ^ ror32(p[2], 5'd1);

    p[3] = ev_s[3] ^ ror32(od_s[3], 5'd3);
    q[3] = od_s[3] ^ ror32(ev_s[3], 5'd4);
    ev_o[3] = ev_s[3] ^ ror32(p[3], 5'd5);
    od_o[3] = od_s[3] ^ ror32(q[3], 5'd5);

    p[4] = ev_s[4] ^ ror32(ev_s[4], 5'd17);
    q[4] = od_s[4] ^ ror32(od_s[4], 5'd17);
    ev_o[4] = ev_s[4] ^ ror32(q[4], 5'd3);
    od_o[4] = od_s[4] ^ ror32(p[4], 5'd4);
  end

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      state_o[i] = {od_o[i], ev_o[i]};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ascon_permutation_interleaved.sv -----
// Top level of the interleaved ASCON permutation core: sequencer and state register.
// Depends on apip_pkg, apip_in_if, apip_out_if and apip_round.
//
// The core takes one 320-bit state in bit-interleaved form per transaction and
// runs rounds start_round through 11 in a single round unit, one round per clock.
// With N = 12 - start_round rounds (N = 0 for start_round of 12 or more), the
// core runs N rounds in the Run state, then holds the result in the Done state
// until it is taken, and it takes its next input in the cycle after the result
// transaction. The input side is not ready while a state is in the core.
`default_nettype none

module ascon_permutation_interleaved (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  apip_in_if.sink         in_i,
  apip_out_if.source      out_o
);
  import apip_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] st_q, st_d;
  round_t     round_q, round_d;
  state_t     lanes_q, lanes_d;
  state_t     round_out;
  logic       in_fire, out_fire;

  apip_round u_round (
    .state_i (lanes_q),
    .round_i (round_q),
    .state_o (round_out)
  );

  assign in_i.ready  = (st_q == StIdle);
  assign out_o.valid = (st_q == StDone);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign out_o.lane0_out = lanes_q[0];
  assign out_o.lane1_out = lanes_q[1];
  assign out_o.lane2_out = lanes_q[2];
  assign out_o.lane3_out = lanes_q[3];
  assign out_o.lane4_out = lanes_q[4];

  always_comb begin
    st_d    = st_q;
    round_d = round_q;
    lanes_d = lanes_q;
    case (st_q)
      StIdle: begin
        if (in_fire) begin
          lanes_d[0] = in_i.lane0_in;
          lanes_d[1] = in_i.lane1_in;
          lanes_d[2] = in_i.lane2_in;
          lanes_d[3] = in_i.lane3_in;
          lanes_d[4] = in_i.lane4_in;
          round_d    = in_i.start_round;
          st_d       = (in_i.start_round < round_t'(RoundCount)) ? StRun : StDone;
        end
      end
      StRun: begin
        lanes_d = round_out;
        round_d = round_q + round_t'(1);
        if (round_q == LastRound) begin
          st_d = StDone;
        end
      end
      StDone: begin
        if (out_fire) begin
          st_d = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      round_q <= '0;
    end else begin
      st_q    <= st_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

`ifndef NO_ASSERTIONS
  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRun) |-> (round_q < round_t'(RoundCount)))
    else $error("round counter out of range while running");

  a_last_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRun && round_q == LastRound) |=> out_o.valid)
    else $error("result not presented after last round");

  a_no_round_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.start_round >= round_t'(RoundCount)) |=>
      (out_o.valid && out_o.lane0_out == $past(in_i.lane0_in)
                   && out_o.lane2_out == $past(in_i.lane2_in)
                   && out_o.lane4_out == $past(in_i.lane4_in)))
    else $error("state not passed through when no rounds run");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while result pending");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/apip_perm_monitor.sv -----
// Monitor for the interleaved ASCON permutation core: predicts each permuted state
// from the input transactions and compares it with the output transactions.
// Depends on apip_pkg, apip_in_if and apip_out_if.
module apip_perm_monitor (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  apip_in_if          in_mon,
  apip_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import apip_pkg::*;

  localparam int unsigned NumRounds = 12;
  localparam logic [3:0] RoundConstEven [NumRounds] = '{
    4'd12, 4'd9, 4'd12, 4'd9, 4'd6, 4'd3, 4'd6, 4'd3, 4'd12, 4'd9, 4'd12, 4'd9
  };
  localparam logic [3:0] RoundConstOdd [NumRounds] = '{
    4'd12, 4'd12, 4'd9, 4'd9, 4'd12, 4'd12, 4'd9, 4'd9, 4'd6, 4'd6, 4'd3, 4'd3
  };

  state_t      expected_states [$];
  int unsigned fails;

  function automatic half_t rotr(half_t x, int unsigned k);
    k = k % 32;
    if (k == 0) return x;
    return (x >> k) | (x << (32 - k));
  endfunction

  function automatic halves_t sbox_layer(halves_t a);
    half_t x0, x1, x2, x3, x4;
    half_t n0, n1, n2, n3, n4;
    halves_t b;
    x0 = a[0]; x1 = a[1]; x2 = a[2]; x3 = a[3]; x4 = a[4];
    x0 ^= x4;
    x4 ^= x3;
    x2 ^= x1;
    n0 = ~x0 & x1;
    n1 = ~x1 & x2;
    n2 = ~x2 & x3;
    n3 = ~x3 & x4;
    n4 = ~x4 & x0;
    x0 ^= n1;
    x1 ^= n2;
    x2 ^= n3;
    x3 ^= n4;
    x4 ^= n0;
    x1 ^= x0;
    x0 ^= x4;
    x3 ^= x2;
    x2 = ~x2;
    b[0] = x0; b[1] = x1; b[2] = x2; b[3] = x3; b[4] = x4;
    return b;
  endfunction

  function automatic state_t permute_interleaved(state_t lanes, round_t first);
    halves_t ev, od;
    half_t   p, q;
    state_t  res;
    for (int i = 0; i < 5; i++) begin
      ev[i] = lanes[i][31:0];
      od[i] = lanes[i][63:32];
    end
    for (int r = int'(first); r < NumRounds; r++) begin
      ev[2] ^= half_t'(RoundConstEven[r]);
      od[2] ^= half_t'(RoundConstOdd[r]);
      ev = sbox_layer(ev);
      od = sbox_layer(od);
      p = ev[0] ^ rotr(od[0], 4);
      q = od[0] ^ rotr(ev[0], 5);
      ev[0] ^= rotr(q, 9);
      od[0] ^= rotr(p, 10);
      p = ev[1] ^ rotr(ev[1], 11);
      q = od[1] ^ rotr(od[1], 11);
      ev[1] ^= rotr(q, 19);
      od[1] ^= rotr(p, 20);
      p = ev[2] ^ rotr(od[2], 2);
      q = od[2] ^ rotr(ev[2], 3);
      ev[2] ^= q;
      od[2] ^= rotr(p, 1);
      p = ev[3] ^ rotr(od[3], 3);
      q = od[3] ^ rotr(ev[3], 4);
      ev[3] ^= rotr(p, 5);
      od[3] ^= rotr(q, 5);
      p = ev[4] ^ rotr(ev[4], 17);
      q = od[4] ^ rotr(od[4], 17);
      ev[4] ^= rotr(q, 3);
      od[4] ^= rotr(p, 4);
    end
    for (int i = 0; i < 5; i++) res[i] = {od[i], ev[i]};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    state_t got, want;
    if (!rst_ni) begin
      expected_states.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        got[0] = in_mon.lane0_in;
        got[1] = in_mon.lane1_in;
        got[2] = in_mon.lane2_in;
        got[3] = in_mon.lane3_in;
        got[4] = in_mon.lane4_in;
        expected_states.push_back(permute_interleaved(got, in_mon.start_round));
      end
      if (out_mon.valid && out_mon.ready) begin
        got[0] = out_mon.lane0_out;
        got[1] = out_mon.lane1_out;
        got[2] = out_mon.lane2_out;
        got[3] = out_mon.lane3_out;
        got[4] = out_mon.lane4_out;
        if (expected_states.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result transaction: %h", got);
        end else begin
          want = expected_states.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got[i] !== want[i]) begin
              fails++;
              if (fails <= 10)
                $display("lane%0d mismatch: expected %h got %h", i, want[i], got[i]);
            end
          end
        end
      end
      fail_cnt_o <= fails;
      pending_o <= expected_states.size();
    end
  end

endmodule

// ----- tb/sv/tb_ascon_permutation_interleaved.sv -----
// Top of the interleaved ASCON permutation testbench: clock, reset, stimulus, verdict.
// Depends on apip_pkg, apip_in_if, apip_out_if, apip_perm_monitor and the core.
module tb_ascon_permutation_interleaved;
  timeunit 1ns;
  timeprecision 1ps;

  import apip_pkg::*;

  localparam int unsigned RandItems  = 400;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned n_sent = 0;

  apip_in_if  in_if ();
  apip_out_if out_if ();

  ascon_permutation_interleaved dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  apip_perm_monitor u_perm_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic state_t rand_state();
    state_t s;
    for (int i = 0; i < 5; i++) s[i] = {$urandom, $urandom};
    return s;
  endfunction

  task automatic drive_state(state_t lanes, round_t first, int unsigned gap);
    in_if.valid       <= 1'b1;
    in_if.lane0_in    <= lanes[0];
    in_if.lane1_in    <= lanes[1];
    in_if.lane2_in    <= lanes[2];
    in_if.lane3_in    <= lanes[3];
    in_if.lane4_in    <= lanes[4];
    in_if.start_round <= first;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stim_proc
    state_t      s;
    round_t      r;
    int unsigned t;
    in_if.valid       <= 1'b0;
    in_if.lane0_in    <= '0;
    in_if.lane1_in    <= '0;
    in_if.lane2_in    <= '0;
    in_if.lane3_in    <= '0;
    in_if.lane4_in    <= '0;
    in_if.start_round <= '0;
    rst_ni            <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_state('0, round_t'(0), pick_gap(1'b0));
    drive_state('1, round_t'(0), pick_gap(1'b0));
    drive_state('1, round_t'(12), pick_gap(1'b0));
    drive_state({5{64'hAAAA_AAAA_5555_5555}}, round_t'(11), pick_gap(1'b0));
    drive_state({5{64'h5555_5555_AAAA_AAAA}}, round_t'(13), pick_gap(1'b0));
    for (int i = 0; i < 5; i++) begin
      s = '0;
      s[i] = '1;
      drive_state(s, round_t'(0), pick_gap(1'b0));
    end
    for (int k = 0; k < 16; k++) drive_state(rand_state(), round_t'(k), pick_gap(k < 8));

    for (int k = 0; k < RandItems; k++) begin
      t = $urandom_range(0, 99);
      if (t < 65) r = round_t'(0);
      else if (t < 95) r = round_t'($urandom_range(1, 12));
      else r = round_t'($urandom_range(13, 15));
      drive_state(rand_state(), r, pick_gap(((k / 40) % 3) == 1));
    end
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : sink_proc
    int unsigned stall;
    int unsigned cyc;
    bit          hold_done;
    stall = 0;
    cyc = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      cyc++;
      if (!hold_done && n_sent >= 120) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
        @(posedge clk_i);
      end else begin
        stall = pick_gap(((cyc / 300) % 3) == 2);
        if (stall == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          stall--;
        end
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog_proc
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ----- ascon_permutation_interleaved.f -----
rtl/core/apip_pkg.sv
rtl/core/apip_if.sv
rtl/core/apip_round.sv
rtl/core/ascon_permutation_interleaved.sv
tb/sv/apip_perm_monitor.sv
tb/sv/tb_ascon_permutation_interleaved.sv
